/* src/toab_pkg.sv */
// Shared types and constants for the textured overlay alpha blend block.
package toab_pkg;

  localparam int PIX_W       = 12;
  localparam int SIZE_W      = 13;
  localparam int SCALE_W     = 20;
  localparam int OFS_W       = 16;
  localparam int BRIGHT_W    = 17;
  localparam int ADDR_W      = 12;
  localparam int TEXEL_W     = 32;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int STORE_DEPTH = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // blend arithmetic: result = floor(X / ALPHA_SPAN), X carries the rounding bias
  localparam int ALPHA_SPAN  = 510;
  localparam int ROUND_BIAS  = 255;
  localparam int RECIP       = 257;   // 2^17 / 257 ~ 510.008
  localparam int RECIP_SHIFT = 17;
  localparam int CH_MAX      = 255;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_BLEND = 1'b1;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_X_VIEW_SCALE = 3'd2,
    REG_Y_VIEW_SCALE = 3'd3,
    REG_U_OFFSET     = 3'd4,
    REG_V_OFFSET     = 3'd5,
    REG_BRIGHTNESS   = 3'd6
  } toab_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [SCALE_W-1:0]  x_view_scale;
    logic [SCALE_W-1:0]  y_view_scale;
    logic [OFS_W-1:0]    u_offset;
    logic [OFS_W-1:0]    v_offset;
    logic [BRIGHT_W-1:0] brightness;
  } toab_cfg_t;

  // one request between front and back: texel load or pixel blend
  typedef struct packed {
    logic               blend;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] data;   // texel for a load, dest color in 23:0 for a blend
  } toab_req_t;

endpackage

/* src/toab_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module toab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/toab_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module toab_div #(
  parameter int DW = 25
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [DW-1:0]              dividend,
  input  logic [toab_pkg::SIZE_W-1:0] divisor,
  output logic [DW-1:0]              quotient
);

  import toab_pkg::*;

  genvar k;
  for (k = 0; k < DW; k++) begin : g_stage
    logic [SIZE_W-1:0] rem_in;
    logic [DW-1:0]     work_in;
    logic [SIZE_W:0]   trial;
    logic              ge;
    logic [SIZE_W-1:0] rem_r;
    logic [DW-1:0]     work_r;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend;
    end else begin : g_next
      assign rem_in  = g_stage[k-1].rem_r;
      assign work_in = g_stage[k-1].work_r;
    end

    assign trial = {rem_in, work_in[DW-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
        work_r <= {work_in[DW-2:0], ge};
      end
    end
  end

  assign quotient = g_stage[DW-1].work_r;

endmodule

/* src/toab_front.sv */
// Front end: accepts requests, maps pixels to texel addresses.
module toab_front #(
  parameter int TEX_WIDTH  = 64,
  parameter int TEX_HEIGHT = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [toab_pkg::ADDR_W-1:0]  in_texel_addr,
  input  logic [toab_pkg::TEXEL_W-1:0] in_texel_rgba,
  input  logic [toab_pkg::PIX_W-1:0]   in_pixel_x,
  input  logic [toab_pkg::PIX_W-1:0]   in_pixel_y,
  input  logic [toab_pkg::CH_W-1:0]    in_dest_red,
  input  logic [toab_pkg::CH_W-1:0]    in_dest_green,
  input  logic [toab_pkg::CH_W-1:0]    in_dest_blue,
  input  toab_pkg::toab_cfg_t          cfg,
  output logic                         push,
  output toab_pkg::toab_req_t          push_req,
  input  logic                         full
);

  import toab_pkg::*;

  localparam int DW = PIX_W + 1 + COORD_BITS;   // (2p+1) << C
  localparam int L  = DW + 4;                   // divide, product, wrap, texel, address
  localparam int PW = DW + SCALE_W;
  localparam int WB = $clog2(TEX_WIDTH + 1);
  localparam int HB = $clog2(TEX_HEIGHT + 1);

  logic [L-1:0]       vld_r;
  toab_req_t          sb_r [L];
  toab_req_t          in_sb;
  logic               adv;
  logic [SIZE_W-1:0]  nx, ny;
  logic [DW-1:0]      qx, qy;
  logic [PW-1:0]      prod_x_r, prod_y_r;
  logic [OFS_W-1:0]   tx16, ty16, u_r, v_r;
  logic [16+WB-1:0]   ucol;
  logic [16+HB-1:0]   vrow;
  logic [WB-1:0]      tcol, tx_r;
  logic [HB-1:0]      trow, ty_r;
  logic [ADDR_W-1:0]  addr_r;

  assign adv      = !vld_r[L-1] || !full;
  assign in_stall = !adv;

  // zero size behaves as one
  assign nx = (cfg.frame_width  == '0) ? SIZE_W'(1) : cfg.frame_width;
  assign ny = (cfg.frame_height == '0) ? SIZE_W'(1) : cfg.frame_height;

  always_comb begin
    in_sb.blend = in_req_type;
    in_sb.addr  = in_texel_addr;
    in_sb.data  = (in_req_type == REQ_BLEND) ?
                  {8'h00, in_dest_blue, in_dest_green, in_dest_red} : in_texel_rgba;
  end

  toab_div #(.DW(DW)) u_div_x (
    .clk      (clk),
    .en       (adv),
    .dividend ({in_pixel_x, 1'b1, COORD_BITS'(0)}),
    .divisor  (nx),
    .quotient (qx)
  );

  toab_div #(.DW(DW)) u_div_y (
    .clk      (clk),
    .en       (adv),
    .dividend ({in_pixel_y, 1'b1, COORD_BITS'(0)}),
    .divisor  (ny),
    .quotient (qy)
  );

  assign tx16 = prod_x_r[COORD_BITS+15:COORD_BITS];
  assign ty16 = prod_y_r[COORD_BITS+15:COORD_BITS];
  assign ucol = (16+WB)'(u_r) * (16+WB)'(TEX_WIDTH);
  assign vrow = (16+HB)'(v_r) * (16+HB)'(TEX_HEIGHT);
  assign tcol = ucol[16+WB-1:16];
  assign trow = vrow[16+HB-1:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= in_sb;
      for (int i = 1; i < L; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
      prod_x_r <= PW'(qx) * PW'(cfg.x_view_scale);
      prod_y_r <= PW'(qy) * PW'(cfg.y_view_scale);
      // u = o + 2s - 2t, v = o - 2s + 2t, fraction only
      u_r <= cfg.u_offset + {cfg.x_view_scale[14:0], 1'b0} - {tx16[14:0], 1'b0};
      v_r <= cfg.v_offset - {cfg.y_view_scale[14:0], 1'b0} + {ty16[14:0], 1'b0};
      tx_r <= (tcol > WB'(TEX_WIDTH - 1))  ? WB'(TEX_WIDTH - 1)  : tcol;
      ty_r <= (trow > HB'(TEX_HEIGHT - 1)) ? HB'(TEX_HEIGHT - 1) : trow;
      addr_r <= ADDR_W'(32'(ty_r) * 32'(TEX_WIDTH) + 32'(tx_r));
    end
  end

  assign push = vld_r[L-1] && !full;

  always_comb begin
    push_req = sb_r[L-1];
    if (sb_r[L-1].blend == REQ_BLEND) begin
      push_req.addr = addr_r;
    end
  end

endmodule

/* src/toab_queue.sv */
// Short request queue between front and back.
module toab_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  toab_pkg::toab_req_t push_req,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output toab_pkg::toab_req_t pop_req
);

  import toab_pkg::*;

  toab_req_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_req = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

/* src/toab_back.sv */
// Back end: texture store access and per-channel alpha blend.
module toab_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  toab_pkg::toab_req_t           q_req,
  input  logic [toab_pkg::BRIGHT_W-1:0] brightness,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [toab_pkg::CH_W-1:0]     out_red,
  output logic [toab_pkg::CH_W-1:0]     out_green,
  output logic [toab_pkg::CH_W-1:0]     out_blue
);

  import toab_pkg::*;

  logic                adv;
  logic [TEXEL_W-1:0]  texel;
  logic [CH_W-1:0]     alpha;
  logic                v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [CH_W-1:0]     dest1_r [NUM_CH];
  logic [15:0]         ca2_r   [NUM_CH];
  logic [16:0]         dd2_r   [NUM_CH];
  logic [17:0]         x3_r    [NUM_CH];
  logic [17:0]         x4_r    [NUM_CH];
  logic [9:0]          q4_r    [NUM_CH];
  logic [CH_W-1:0]     res_r   [NUM_CH];
  logic [32:0]         cb      [NUM_CH];
  logic [26:0]         xr      [NUM_CH];
  logic [17:0]         rem     [NUM_CH];
  logic [9:0]          rq      [NUM_CH];

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = q_valid && adv;
  assign alpha = texel[31:24];

  toab_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (q_pop && (q_req.blend == REQ_LOAD)),
    .waddr (q_req.addr),
    .wdata (q_req.data),
    .re    (q_pop && (q_req.blend == REQ_BLEND)),
    .raddr (q_req.addr),
    .rdata (texel)
  );

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      cb[c]  = 33'(ca2_r[c]) * 33'(brightness);
      xr[c]  = 27'(x3_r[c]) * 27'(RECIP);
      rem[c] = x4_r[c] - 18'(q4_r[c]) * 18'(ALPHA_SPAN);
      rq[c]  = q4_r[c] + ((rem[c] >= 18'(ALPHA_SPAN)) ? 10'd1 : 10'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_pop && (q_req.blend == REQ_BLEND);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        dest1_r[c] <= q_req.data[c*CH_W +: CH_W];
        // c*A, and d*(510-A) plus the rounding bias already shifted down
        ca2_r[c]   <= 16'(texel[c*CH_W +: CH_W]) * 16'(alpha);
        dd2_r[c]   <= 17'(dest1_r[c]) * 17'(9'(ALPHA_SPAN) - 9'(alpha)) + 17'(ROUND_BIAS);
        x3_r[c]    <= 18'(cb[c][32:16]) + 18'(dd2_r[c]);
        x4_r[c]    <= x3_r[c];
        q4_r[c]    <= xr[c][26:RECIP_SHIFT];
        res_r[c]   <= (rq[c] > 10'(CH_MAX)) ? CH_W'(CH_MAX) : rq[c][CH_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = res_r[0];
  assign out_green = res_r[1];
  assign out_blue  = res_r[2];

endmodule

/* src/textured_overlay_alpha_blend_top.sv */
// Top level of the textured overlay alpha blend block with its register file.
//
// Streams one request per clock unless stalled. A load request (req_type 0) writes one RGBA
// texel into the 4096-entry texture store and returns nothing; a blend request
// (req_type 1) maps the pixel center onto the view plane, samples the texture
// nearest-neighbor and blends it over the given dest color, returning one
// result. Requests keep their order, so a blend sees every earlier load.
// Throughput is one request per cycle when no stall holds it. A blend passes
// through the pixel-center divide (one quotient bit per stage), the
// coordinate/address math (product, wrap, texel, address), the request
// queue, then a registered texture read and 4 blend stages ending in the
// output register. Reading a texel that was never loaded gives an undefined
// color. Registers (APB, byte address 4*i) may only be written while idle.
module textured_overlay_alpha_blend_top #(
  parameter int TEX_WIDTH  = 64,
  parameter int TEX_HEIGHT = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [toab_pkg::ADDR_W-1:0]     in_texel_addr,
  input  logic [toab_pkg::TEXEL_W-1:0]    in_texel_rgba,
  input  logic [toab_pkg::PIX_W-1:0]      in_pixel_x,
  input  logic [toab_pkg::PIX_W-1:0]      in_pixel_y,
  input  logic [toab_pkg::CH_W-1:0]       in_dest_red,
  input  logic [toab_pkg::CH_W-1:0]       in_dest_green,
  input  logic [toab_pkg::CH_W-1:0]       in_dest_blue,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [toab_pkg::CH_W-1:0]       out_red,
  output logic [toab_pkg::CH_W-1:0]       out_green,
  output logic [toab_pkg::CH_W-1:0]       out_blue,
  // register port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [toab_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [toab_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [toab_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  import toab_pkg::*;

  toab_cfg_t cfg_r;
  toab_reg_t reg_sel;
  logic      cfg_wr;
  logic      push, full, q_valid, q_pop;
  toab_req_t push_req, pop_req;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = toab_reg_t'(cfg_paddr[4:2]);

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= SIZE_W'(640);
      cfg_r.frame_height <= SIZE_W'(480);
      cfg_r.x_view_scale <= SCALE_W'(30600);
      cfg_r.y_view_scale <= SCALE_W'(22950);
      cfg_r.u_offset     <= '0;
      cfg_r.v_offset     <= '0;
      cfg_r.brightness   <= BRIGHT_W'(65536);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_pwdata[SIZE_W-1:0];
        REG_X_VIEW_SCALE: cfg_r.x_view_scale <= cfg_pwdata[SCALE_W-1:0];
        REG_Y_VIEW_SCALE: cfg_r.y_view_scale <= cfg_pwdata[SCALE_W-1:0];
        REG_U_OFFSET:     cfg_r.u_offset     <= cfg_pwdata[OFS_W-1:0];
        REG_V_OFFSET:     cfg_r.v_offset     <= cfg_pwdata[OFS_W-1:0];
        REG_BRIGHTNESS:   cfg_r.brightness   <= cfg_pwdata[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(cfg_r.frame_height);
      REG_X_VIEW_SCALE: cfg_prdata = CFG_DATA_W'(cfg_r.x_view_scale);
      REG_Y_VIEW_SCALE: cfg_prdata = CFG_DATA_W'(cfg_r.y_view_scale);
      REG_U_OFFSET:     cfg_prdata = CFG_DATA_W'(cfg_r.u_offset);
      REG_V_OFFSET:     cfg_prdata = CFG_DATA_W'(cfg_r.v_offset);
      REG_BRIGHTNESS:   cfg_prdata = CFG_DATA_W'(cfg_r.brightness);
      default:          cfg_prdata = '0;
    endcase
  end

  // front: pixel center divide, view-plane wrap, texel address
  toab_front #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_texel_addr (in_texel_addr),
    .in_texel_rgba (in_texel_rgba),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_dest_red   (in_dest_red),
    .in_dest_green (in_dest_green),
    .in_dest_blue  (in_dest_blue),
    .cfg           (cfg_r),
    .push          (push),
    .push_req      (push_req),
    .full          (full)
  );

  // decouples front stalls from back stalls
  toab_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_req  (pop_req)
  );

  // back: texture store and blend
  toab_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_req      (pop_req),
    .brightness (cfg_r.brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule
